FILE: rtl/wrse_pkg.sv
// types and constants shared by the windowed rate slope estimator
`timescale 1ns / 1ps
package wrse_pkg;

    localparam int TPS_W = 20;
    localparam logic [TPS_W-1:0] TPS_RESET = 20'd1000;

    typedef struct packed {
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic [31:0]        sample_time;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic               no_time_spread;
        logic               saturated;
    } result_t;

endpackage

FILE: rtl/windowed_rate_slope_estimator.sv
// top level: least-squares angular acceleration over a sliding sample window
// samples are worked one at a time, by a serial walk over the ring (a sum pass, then
// a pass of deviation products per entry) and a scaling and serial division per axis
// a two-entry input queue accepts samples while one is in work; result held until pop
// reset clears the window to zero samples, the slot pointer to 0, ticks per second to 1000
`timescale 1ns / 1ps
module windowed_rate_slope_estimator
    import wrse_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sample_t          in_item,
    output logic             empty,
    input  logic             pop,
    output result_t          out_item,
    input  logic             cfg_we,
    input  logic [TPS_W-1:0] cfg_data
);

    localparam int LW = $clog2(HISTORY_DEPTH);
    localparam int QW = LW + $bits(sample_t);

    logic [TPS_W-1:0] tps_reg;
    logic             q_wr;
    logic [QW-1:0]    q_wdata;
    logic             q_full;
    logic             q_rd;
    logic [QW-1:0]    q_rdata;
    logic             q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= TPS_RESET;
        else if (cfg_we)
            tps_reg <= cfg_data;
    end

    wrse_front #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SW(LW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_item(in_item),
        .q_wr(q_wr),
        .q_wdata(q_wdata),
        .q_full(q_full)
    );

    wrse_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(q_wr),
        .wr_data(q_wdata),
        .q_full(q_full),
        .rd_en(q_rd),
        .rd_data(q_rdata),
        .q_empty(q_empty)
    );

    wrse_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .LW(LW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_rd(q_rd),
        .q_rdata(q_rdata),
        .tps(tps_reg),
        .empty(empty),
        .pop(pop),
        .out_item(out_item)
    );

endmodule

FILE: rtl/wrse_queue.sv
// two-entry queue between the front and back parts
`timescale 1ns / 1ps
module wrse_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en && !q_full)
            begin
                slot_reg[wr_ptr_reg] <= wr_data;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en && !q_empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((wr_en && !q_full) ? 1 : 0)
                                   - 2'((rd_en && !q_empty) ? 1 : 0);
        end
    end

endmodule

FILE: rtl/wrse_front.sv
// front part: accepts samples and assigns each its ring slot
`timescale 1ns / 1ps
module wrse_front
    import wrse_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8,
    parameter int SW = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  sample_t       in_item,
    output logic          q_wr,
    output logic [SW+$bits(sample_t)-1:0] q_wdata,
    input  logic          q_full
);

    logic [SW-1:0] slot_reg;
    logic          take;

    assign take    = push && !q_full;
    assign full    = q_full;
    assign q_wr    = take;
    assign q_wdata = {slot_reg, in_item};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (take)
        begin
            if (slot_reg == SW'(HISTORY_DEPTH - 1))
                slot_reg <= '0;
            else
                slot_reg <= slot_reg + 1'b1;
        end
    end

endmodule

FILE: rtl/wrse_back.sv
// back part: ring store, least-squares sums, scaling and serial division
`timescale 1ns / 1ps
module wrse_back
    import wrse_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8,
    parameter int LW = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_rd,
    input  logic [LW+$bits(sample_t)-1:0] q_rdata,
    input  logic [TPS_W-1:0] tps,
    output logic             empty,
    input  logic             pop,
    output result_t          out_item
);

    localparam int DMW  = 32 + LW;
    localparam int DEVW = DMW + 1;
    localparam int DENW = 2 * DMW + LW;
    localparam int NUMW = DMW + 32 + LW;
    localparam int MW   = NUMW - 1;
    localparam int SCLW = TPS_W + LW;
    localparam int SCW  = MW + SCLW;
    localparam int NCH  = (MW + 31) / 32;
    localparam int CKW  = (NCH > 1) ? $clog2(NCH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRD, ST_SACC, ST_ERD, ST_EDEV, ST_EM0, ST_EM1, ST_EM2,
        ST_EM3, ST_EM4, ST_ASET, ST_ASCM, ST_ASCA, ST_ACHK, ST_ADIV, ST_AFIN
    } state_t;

    state_t state_reg;
    logic   done_reg;

    sample_t         ring_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    sample_t         rd_entry_reg;
    logic            rd_valid_reg;
    sample_t         entry;
    sample_t         q_item;
    logic [LW-1:0]   q_slot;
    logic [LW-1:0]   idx_reg;
    logic            wr_now;

    logic [DMW-1:0]          sum_reg;
    logic [DMW-1:0]          dm_reg;
    logic                    dneg_reg;
    logic signed [31:0]      wx_reg, wy_reg, wz_reg;
    logic [2*DMW-1:0]        prod_reg;
    logic [DENW-1:0]         den_reg;
    logic signed [NUMW-1:0]  numx_reg, numy_reg, numz_reg;
    logic [1:0]              axis_reg;
    logic                    neg_reg;
    logic [NCH*32-1:0]       magp_reg;
    logic [CKW-1:0]          k_reg;
    logic [SCW-1:0]          scaled_reg;
    logic [DENW:0]           rem_reg;
    logic [31:0]             lo_reg;
    logic [31:0]             quo_reg;
    logic [4:0]              cnt_reg;
    logic                    big_reg;
    logic [31:0]             ax_reg, ay_reg, az_reg;
    logic                    sat_reg;
    result_t                 out_reg;
    logic                    out_valid_reg;

    logic [DMW-1:0]          mul_a, mul_b;
    logic [DMW-1:0]          nt;
    logic signed [DEVW-1:0]  dev;
    logic [DMW-1:0]          dm;
    logic signed [NUMW-1:0]  term;
    logic signed [NUMW-1:0]  num_sel;
    logic [NUMW-1:0]         mag;
    logic [SCLW-1:0]         scale;
    logic [DENW-1:0]         hi_part;
    logic [DENW:0]           trial;
    logic [31:0]             res;
    logic                    res_sat;

    assign q_item = q_rdata[$bits(sample_t)-1:0];
    assign q_slot = q_rdata[LW+$bits(sample_t)-1:$bits(sample_t)];
    assign wr_now = (state_reg == ST_IDLE) && !q_empty && !done_reg;
    assign q_rd   = wr_now;
    assign entry  = rd_valid_reg ? rd_entry_reg : '0;
    assign empty  = !out_valid_reg;
    assign out_item = out_reg;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // ring store, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_now)
            ring_mem[q_slot] <= q_item;
        rd_entry_reg <= ring_mem[idx_reg];
    end

    always_comb
    begin
        nt    = DMW'(entry.sample_time) * DMW'(HISTORY_DEPTH);
        dev   = $signed({1'b0, nt}) - $signed({1'b0, sum_reg});
        dm    = dev[DEVW-1] ? DMW'(-dev) : DMW'(dev);
        scale = SCLW'(tps) * SCLW'(HISTORY_DEPTH);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EM0:
            begin
                mul_a = dm_reg;
                mul_b = dm_reg;
            end
            ST_EM1:
            begin
                mul_a = dm_reg;
                mul_b = DMW'(abs32(wx_reg));
            end
            ST_EM2:
            begin
                mul_a = dm_reg;
                mul_b = DMW'(abs32(wy_reg));
            end
            ST_EM3:
            begin
                mul_a = dm_reg;
                mul_b = DMW'(abs32(wz_reg));
            end
            ST_ASCM:
            begin
                mul_a = DMW'(magp_reg[32*k_reg +: 32]);
                mul_b = DMW'(scale);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        term = $signed(NUMW'(prod_reg));
        case (axis_reg)
            2'd0:    num_sel = numx_reg;
            2'd1:    num_sel = numy_reg;
            default: num_sel = numz_reg;
        endcase
        mag     = num_sel[NUMW-1] ? NUMW'(-num_sel) : NUMW'(num_sel);
        hi_part = DENW'(scaled_reg[SCW-1:32]);
        trial   = {rem_reg[DENW-1:0], lo_reg[31]};
        if (!neg_reg)
        begin
            res_sat = big_reg || (quo_reg > 32'h7FFF_FFFF);
            res     = res_sat ? 32'h7FFF_FFFF : quo_reg;
        end
        else
        begin
            res_sat = big_reg || (quo_reg > 32'h8000_0000);
            res     = res_sat ? 32'h8000_0000 : (32'd0 - quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            dm_reg        <= '0;
            dneg_reg      <= 1'b0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            wz_reg        <= '0;
            prod_reg      <= '0;
            den_reg       <= '0;
            numx_reg      <= '0;
            numy_reg      <= '0;
            numz_reg      <= '0;
            axis_reg      <= '0;
            neg_reg       <= 1'b0;
            magp_reg      <= '0;
            k_reg         <= '0;
            scaled_reg    <= '0;
            rem_reg       <= '0;
            lo_reg        <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            big_reg       <= 1'b0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            az_reg        <= '0;
            sat_reg       <= 1'b0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[idx_reg];
            prod_reg     <= mul_a * mul_b;
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (done_reg)
                    begin
                        if (!out_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            done_reg      <= 1'b0;
                            if (den_reg == '0)
                                out_reg <= '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0};
                            else
                                out_reg <= '{ax_reg, ay_reg, az_reg, 1'b0, sat_reg};
                        end
                    end
                    else if (!q_empty)
                    begin
                        valid_reg[q_slot] <= 1'b1;
                        idx_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= ST_SRD;
                    end
                end
                ST_SRD:
                begin
                    state_reg <= ST_SACC;
                end
                ST_SACC:
                begin
                    sum_reg <= sum_reg + DMW'(entry.sample_time);
                    if (idx_reg == LW'(HISTORY_DEPTH - 1))
                    begin
                        idx_reg   <= '0;
                        den_reg   <= '0;
                        numx_reg  <= '0;
                        numy_reg  <= '0;
                        numz_reg  <= '0;
                        state_reg <= ST_ERD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SRD;
                    end
                end
                ST_ERD:
                begin
                    state_reg <= ST_EDEV;
                end
                ST_EDEV:
                begin
                    dm_reg    <= dm;
                    dneg_reg  <= dev[DEVW-1];
                    wx_reg    <= entry.rate_x;
                    wy_reg    <= entry.rate_y;
                    wz_reg    <= entry.rate_z;
                    state_reg <= ST_EM0;
                end
                ST_EM0:
                begin
                    state_reg <= ST_EM1;
                end
                ST_EM1:
                begin
                    den_reg   <= den_reg + DENW'(prod_reg);
                    state_reg <= ST_EM2;
                end
                ST_EM2:
                begin
                    numx_reg  <= (dneg_reg ^ wx_reg[31]) ? numx_reg - term : numx_reg + term;
                    state_reg <= ST_EM3;
                end
                ST_EM3:
                begin
                    numy_reg  <= (dneg_reg ^ wy_reg[31]) ? numy_reg - term : numy_reg + term;
                    state_reg <= ST_EM4;
                end
                ST_EM4:
                begin
                    numz_reg <= (dneg_reg ^ wz_reg[31]) ? numz_reg - term : numz_reg + term;
                    if (idx_reg == LW'(HISTORY_DEPTH - 1))
                    begin
                        idx_reg  <= '0;
                        axis_reg <= '0;
                        sat_reg  <= 1'b0;
                        if (den_reg == '0)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_ASET;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_ERD;
                    end
                end
                ST_ASET:
                begin
                    neg_reg    <= num_sel[NUMW-1];
                    magp_reg   <= (NCH*32)'(mag[MW-1:0]);
                    scaled_reg <= '0;
                    k_reg      <= '0;
                    state_reg  <= ST_ASCM;
                end
                ST_ASCM:
                begin
                    state_reg <= ST_ASCA;
                end
                ST_ASCA:
                begin
                    scaled_reg <= scaled_reg + (SCW'(prod_reg) << {k_reg, 5'b0});
                    if (k_reg == CKW'(NCH - 1))
                    begin
                        state_reg <= ST_ACHK;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_ASCM;
                    end
                end
                ST_ACHK:
                begin
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    lo_reg  <= scaled_reg[31:0];
                    rem_reg <= {1'b0, hi_part};
                    if (hi_part >= den_reg)
                    begin
                        big_reg   <= 1'b1;
                        state_reg <= ST_AFIN;
                    end
                    else
                    begin
                        big_reg   <= 1'b0;
                        state_reg <= ST_ADIV;
                    end
                end
                ST_ADIV:
                begin
                    lo_reg <= {lo_reg[30:0], 1'b0};
                    if (trial >= {1'b0, den_reg})
                    begin
                        rem_reg <= trial - {1'b0, den_reg};
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_reg <= ST_AFIN;
                end
                ST_AFIN:
                begin
                    sat_reg <= sat_reg | res_sat;
                    case (axis_reg)
                        2'd0:    ax_reg <= res;
                        2'd1:    ay_reg <= res;
                        default: az_reg <= res;
                    endcase
                    if (axis_reg == 2'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_ASET;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: verif/testbench.sv
// testbench for the windowed rate slope estimator with an in-bench least-squares predictor
`timescale 1ns / 1ps
module testbench;
    import wrse_pkg::*;

    localparam int DEPTH = 8;
    localparam int SETTLE = 260;
    localparam int LIMIT = 2000000;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    sample_t          in_item;
    logic             empty;
    logic             pop;
    result_t          out_item;
    logic             cfg_we;
    logic [TPS_W-1:0] cfg_data;

    windowed_rate_slope_estimator #(.HISTORY_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    logic [31:0]      ring_x [DEPTH];
    logic [31:0]      ring_y [DEPTH];
    logic [31:0]      ring_z [DEPTH];
    logic [31:0]      ring_t [DEPTH];
    int               next_slot;
    logic [TPS_W-1:0] tps;
    result_t          pending_slopes [$];
    int               errors;
    int               cycles;
    int               send_idle_pct;
    int               recv_stall_pct;
    logic             hold_rx;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [31:0] clip_slope(logic signed [127:0] num,
                                               logic [127:0] den, ref bit sat);
        logic [127:0] mag;
        logic [127:0] scaled;
        logic [127:0] q;
        logic         neg;
        neg = num[127];
        mag = num;
        if (neg)
            mag = -num;
        scaled = mag * {105'd0, tps, 3'd0};
        q = scaled / den;
        if (!neg)
        begin
            if (q > 128'h7FFF_FFFF)
            begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -q[31:0];
    endfunction

    function automatic result_t predict_slope(sample_t s);
        logic signed [127:0] dev [DEPTH];
        logic signed [127:0] nx;
        logic signed [127:0] ny;
        logic signed [127:0] nz;
        logic [127:0]        den;
        logic [63:0]         sum_t;
        result_t             r;
        bit                  sat;
        ring_x[next_slot] = s.rate_x;
        ring_y[next_slot] = s.rate_y;
        ring_z[next_slot] = s.rate_z;
        ring_t[next_slot] = s.sample_time;
        next_slot = (next_slot + 1) % DEPTH;
        sum_t = 0;
        for (int i = 0; i < DEPTH; i++)
            sum_t += ring_t[i];
        den = 0;
        nx = 0;
        ny = 0;
        nz = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            dev[i] = $signed({93'd0, ring_t[i], 3'd0}) - $signed({64'd0, sum_t});
            den += dev[i] * dev[i];
            nx += dev[i] * $signed({{96{ring_x[i][31]}}, ring_x[i]});
            ny += dev[i] * $signed({{96{ring_y[i][31]}}, ring_y[i]});
            nz += dev[i] * $signed({{96{ring_z[i][31]}}, ring_z[i]});
        end
        r = '0;
        if (den == 0)
        begin
            r.no_time_spread = 1'b1;
            return r;
        end
        sat = 1'b0;
        r.accel_x = clip_slope(nx, den, sat);
        r.accel_y = clip_slope(ny, den, sat);
        r.accel_z = clip_slope(nz, den, sat);
        r.saturated = sat;
        return r;
    endfunction

    // result side: check each transfer, then choose pop for the next edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_slopes.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_item);
                errors++;
            end
            else
            begin
                want = pending_slopes.pop_front();
                if (out_item.accel_x !== want.accel_x)
                    $display("%0t accel_x expected %h actual %h", $time, want.accel_x,
                             out_item.accel_x);
                if (out_item.accel_y !== want.accel_y)
                    $display("%0t accel_y expected %h actual %h", $time, want.accel_y,
                             out_item.accel_y);
                if (out_item.accel_z !== want.accel_z)
                    $display("%0t accel_z expected %h actual %h", $time, want.accel_z,
                             out_item.accel_z);
                if (out_item.no_time_spread !== want.no_time_spread)
                    $display("%0t no_time_spread expected %b actual %b", $time,
                             want.no_time_spread, out_item.no_time_spread);
                if (out_item.saturated !== want.saturated)
                    $display("%0t saturated expected %b actual %b", $time, want.saturated,
                             out_item.saturated);
                if (out_item !== want)
                    errors++;
            end
        end
        pop <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(sample_t s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        push <= 1'b1;
        in_item <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_slopes.push_back(predict_slope(s));
    endtask

    task automatic send_fields(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] t);
        sample_t s;
        s.rate_x = x;
        s.rate_y = y;
        s.rate_z = z;
        s.sample_time = t;
        send_sample(s);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending_slopes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_tps(logic [TPS_W-1:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tps = v;
    endtask

    task automatic test_stale_and_flat();
        // first sample at time 0 over a zero ring: no spread
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'd0);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'd5);
        send_fields(32'd0, 32'd1, 32'hFFFF_FFFF, 32'd10);
        for (int i = 0; i < 8; i++)
            send_fields(32'h0012_3456, 32'hFFED_CBAA, 32'd7, 32'd77);
    endtask

    task automatic test_extremes();
        for (int i = 0; i < 8; i++)
            send_fields(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                        i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                        $urandom, i[0] ? 32'hFFFF_FFFF : 32'd0);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
        send_fields(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_saturation();
        write_tps(20'hFFFFF);
        for (int i = 0; i < 8; i++)
            send_fields(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'd1 << i,
                        i[1] ? 32'h7FFF_FFFF : 32'h8000_0000, 32'd1000 + i[0]);
    endtask

    task automatic test_zero_tps();
        write_tps('0);
        for (int i = 0; i < 4; i++)
            send_fields($urandom, $urandom, $urandom, $urandom);
        write_tps(20'd1);
        for (int i = 0; i < 4; i++)
            send_fields($urandom, $urandom, $urandom, 32'd500 + i);
    endtask

    task automatic run_random(int n);
        logic [31:0] t;
        t = $urandom;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: send_fields($urandom, $urandom, $urandom, $urandom);
                1: send_fields($urandom, $urandom, $urandom, t);
                2, 3:
                begin
                    t += $urandom_range(20);
                    send_fields($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                                $urandom_range(65535) - 32768, t);
                end
                default:
                begin
                    t += $urandom_range(1, 2000);
                    send_fields($urandom, $urandom, $urandom, t);
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_rx <= 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_rx <= 1'b0;
            end
        join_none
        run_random(10);
    endtask

    task automatic test_random_phases();
        int tps_pick [4] = '{1000, 1, 1000000, 48000};
        for (int p = 0; p < 4; p++)
        begin
            write_tps(TPS_W'(tps_pick[p]));
            send_idle_pct = (p == 1) ? 76 : (p == 3) ? 11 : 0;
            recv_stall_pct = (p == 2) ? 76 : (p == 3) ? 11 : 0;
            run_random(355);
            write_tps(TPS_W'($urandom_range(1, 1000000)));
            run_random(5);
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_x[i] = 0;
            ring_y[i] = 0;
            ring_z[i] = 0;
            ring_t[i] = 0;
        end
        next_slot = 0;
        tps = TPS_RESET;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_rx = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        pop = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stale_and_flat();
        test_extremes();
        test_saturation();
        test_zero_tps();
        write_tps(TPS_RESET);
        test_backpressure();
        test_random_phases();
        drain();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
